FILE: rtl/max_falling_path_sum_defines.svh
// Assertion macros shared by the block's checkers.
`ifndef MAX_FALLING_PATH_SUM_DEFINES_SVH
`define MAX_FALLING_PATH_SUM_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted.
`define MFPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define MFPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define MFPS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mfps_pkg.sv
// Shared constants and types of the max falling path sum block.
`timescale 1ns / 1ps

package mfps_pkg;

    localparam int CELL_W         = 16;
    localparam int SUM_W          = 32;
    localparam int CFG_W          = 7;
    localparam int MAX_COLS_DEF   = 64;
    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [CFG_W-1:0]        ROW_WIDTH_RESET = 7'd4;
    localparam logic signed [SUM_W-1:0] SUM_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN         = 32'sh8000_0000;

    typedef struct packed {
        logic             saturated;
        logic [SUM_W-1:0] best_sum;
    } out_item_t;

endpackage

FILE: rtl/max_falling_path_sum.sv
// Top level: streaming maximum falling path sum over a row-major matrix.
`timescale 1ns / 1ps

// Usage
//   s_* channel: one matrix cell per transfer, row-major; s_tlast marks the final cell.
//   m_* channel: one transfer per matrix, the largest path sum of the final row
//     (m_tdata) and a flag that some sum of the matrix clipped to 32-bit range (m_tuser).
//   cfg_* channel: row width, 1..64; 0 acts as 1, above MAX_COLS as MAX_COLS.
//     Write it only while no cell is in flight; it applies from the next cell on.
// Timing
//   One cell per cycle, sustained while s_tready is high. A cell reads its column
//   and its right neighbor from the line buffer in the transfer cycle, sums in the
//   next, and the row maximum is folded in the cycle after that. Stage C queues a
//   final cell's result for m_*. The single write port of the line buffer takes
//   one write per cycle, which sets the rate at one cell per clock.
// Reset
//   aresetn (synchronous, active low) returns the block to the start of a matrix at
//   row width 4 and empties the result queue. The line buffer is not cleared; the
//   first row of a matrix always writes before any later row reads.
// Stall
//   Results queue in a four-entry buffer. s_tready drops once queued results plus
//   final cells still in the pipeline fill it, so no result is ever lost.

module max_falling_path_sum import mfps_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input cells
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CELL_W-1:0] s_tdata,   // [15:0] cell_value (signed)
    input  logic              s_tlast,   // last_cell
    // results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [SUM_W-1:0]  m_tdata,   // [31:0] best_sum (signed)
    output logic [0:0]        m_tuser,   // [0] saturated
    // row width register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data   // [6:0] row_width
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);
    localparam logic signed [SUM_W+1:0] WIDE_MAX = (SUM_W+2)'(SUM_MAX);
    localparam logic signed [SUM_W+1:0] WIDE_MIN = (SUM_W+2)'(SUM_MIN);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] row_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_valid) begin
            row_width_reg <= cfg_data;
        end
    end

    // ---------------- stage A: column tracking, buffer read ----------------
    logic [31:0]   width_eff;
    logic [AW-1:0] last_col;
    logic [AW-1:0] col_reg, col_next;
    logic          first_row_reg, first_row_next;
    logic [AW-1:0] col_a;
    logic          row_end_a;
    logic          accept;

    always_comb begin
        if (row_width_reg == '0) begin
            width_eff = 32'd1;
        end else begin
            width_eff = 32'(row_width_reg);
        end
        if (width_eff > 32'(MAX_COLS)) begin
            width_eff = 32'(MAX_COLS);
        end
    end

    assign last_col  = AW'(width_eff - 32'd1);
    // a column past a shrunk width counts as the row's last one
    assign col_a     = (col_reg >= last_col) ? last_col : col_reg;
    assign row_end_a = (col_a == last_col);
    assign accept    = s_tvalid & s_tready;

    always_comb begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept) begin
            if (s_tlast) begin
                col_next       = '0;
                first_row_next = 1'b1;
            end else if (row_end_a) begin
                col_next       = '0;
                first_row_next = 1'b0;
            end else begin
                col_next       = col_a + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end else begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // ---------------- stage B: neighbor select, add, saturate, write back ----------------
    logic                     b_valid_reg;
    logic                     b_last_reg;
    logic                     b_first_reg;
    logic                     b_row_end_reg;
    logic                     b_has_right_reg;
    logic [AW-1:0]            b_col_reg;
    logic signed [CELL_W-1:0] b_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_last_reg      <= s_tlast;
            b_first_reg     <= first_row_reg;
            b_row_end_reg   <= row_end_a;
            b_has_right_reg <= !row_end_a;
            b_col_reg       <= col_a;
            b_value_reg     <= s_tdata;
        end
    end

    logic [SUM_W-1:0] rd_data0, rd_data1;
    logic             wr_en;
    logic [SUM_W-1:0] wr_data;

    mfps_row_mem #(
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_row_mem (
        .aclk     (aclk),
        .we       (wr_en),
        .wr_addr  (b_col_reg),
        .wr_data  (wr_data),
        .re       (accept),
        .rd_addr0 (col_a),
        .rd_addr1 (col_a + AW'(1)),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    // Last write, forwarded: a read issued in the same cycle as a write to the
    // same column returns the old word (row width 1 or 2 at a row turn).
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [SUM_W-1:0]        fwd_data_reg;
    logic signed [SUM_W-1:0] left_old_reg;
    logic signed [SUM_W-1:0] old_here;
    logic signed [SUM_W-1:0] old_right;
    logic signed [SUM_W-1:0] best_prev;
    logic signed [SUM_W+1:0] sum_wide;
    logic signed [SUM_W-1:0] b_sum;
    logic                    b_sat;

    always_comb begin
        old_here  = (fwd_valid_reg && fwd_addr_reg == b_col_reg) ?
                    fwd_data_reg : rd_data0;
        old_right = (fwd_valid_reg && fwd_addr_reg == (b_col_reg + AW'(1))) ?
                    fwd_data_reg : rd_data1;

        best_prev = old_here;
        if (b_col_reg != '0 && left_old_reg > best_prev) begin
            best_prev = left_old_reg;
        end
        if (b_has_right_reg && old_right > best_prev) begin
            best_prev = old_right;
        end

        sum_wide = (SUM_W+2)'(b_value_reg) + (SUM_W+2)'(best_prev);

        b_sat = 1'b0;
        if (b_first_reg) begin
            b_sum = SUM_W'(b_value_reg);
        end else if (sum_wide > WIDE_MAX) begin
            b_sum = SUM_MAX;
            b_sat = 1'b1;
        end else if (sum_wide < WIDE_MIN) begin
            b_sum = SUM_MIN;
            b_sat = 1'b1;
        end else begin
            b_sum = SUM_W'(sum_wide);
        end
    end

    assign wr_en   = b_valid_reg;
    assign wr_data = b_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (b_valid_reg) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            fwd_addr_reg <= b_col_reg;
            fwd_data_reg <= b_sum;
            left_old_reg <= old_here;
        end
    end

    // ---------------- stage C: row maximum, saturation flag, result ----------------
    logic                    c_valid_reg;
    logic                    c_last_reg;
    logic                    c_row_end_reg;
    logic                    c_sat_reg;
    logic signed [SUM_W-1:0] c_sum_reg;
    logic signed [SUM_W-1:0] row_max_reg, row_max_next;
    logic                    sat_seen_reg, sat_seen_next;
    logic signed [SUM_W-1:0] row_max_new;
    logic                    push;
    out_item_t               push_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            c_last_reg    <= b_last_reg;
            c_row_end_reg <= b_row_end_reg;
            c_sat_reg     <= b_sat;
            c_sum_reg     <= b_sum;
        end
    end

    assign row_max_new = (c_sum_reg > row_max_reg) ? c_sum_reg : row_max_reg;

    always_comb begin
        row_max_next  = row_max_reg;
        sat_seen_next = sat_seen_reg;
        if (c_valid_reg) begin
            if (c_last_reg) begin
                row_max_next  = SUM_MIN;
                sat_seen_next = 1'b0;
            end else begin
                row_max_next  = c_row_end_reg ? SUM_MIN : row_max_new;
                sat_seen_next = sat_seen_reg | c_sat_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_max_reg  <= SUM_MIN;
            sat_seen_reg <= 1'b0;
        end else begin
            row_max_reg  <= row_max_next;
            sat_seen_reg <= sat_seen_next;
        end
    end

    assign push                = c_valid_reg & c_last_reg;
    assign push_item.saturated = sat_seen_reg | c_sat_reg;
    assign push_item.best_sum  = row_max_new;

    // ---------------- result queue and input credit ----------------
    out_item_t     out_item;
    logic [CW-1:0] fifo_count;
    logic [CW:0]   pending;

    mfps_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .count     (fifo_count)
    );

    assign m_tdata    = out_item.best_sum;
    assign m_tuser[0] = out_item.saturated;

    // queued results plus final cells still in stages B and C
    assign pending  = (CW+1)'(fifo_count)
                    + (CW+1)'(b_valid_reg & b_last_reg)
                    + (CW+1)'(c_valid_reg & c_last_reg);
    assign s_tready = (pending < (CW+1)'(OUT_FIFO_DEPTH));

endmodule

FILE: rtl/mfps_row_mem.sv
// Line buffer: one write port, two registered read ports.
`timescale 1ns / 1ps

module mfps_row_mem import mfps_pkg::*; #(
    parameter int DEPTH = MAX_COLS_DEF,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [SUM_W-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr0,
    input  logic [AW-1:0]    rd_addr1,
    output logic [SUM_W-1:0] rd_data0,
    output logic [SUM_W-1:0] rd_data1
);

    logic [SUM_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

FILE: rtl/mfps_out_fifo.sv
// Small result queue in front of the master channel.
`timescale 1ns / 1ps

module mfps_out_fifo import mfps_pkg::*; (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  out_item_t                            push_item,
    input  logic                                 pop_ready,
    output logic                                 out_valid,
    output out_item_t                            out_item,
    output logic [$clog2(OUT_FIFO_DEPTH+1)-1:0]  count
);

    localparam int PW = (OUT_FIFO_DEPTH > 1) ? $clog2(OUT_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

    out_item_t     q_mem [OUT_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = q_mem[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid & pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/mfps_port_checker.sv
// Port-level checker for max_falling_path_sum, bound to the top level.
`timescale 1ns / 1ps
`include "max_falling_path_sum_defines.svh"

module mfps_port_checker import mfps_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [SUM_W-1:0]  m_tdata,
    input logic [0:0]        m_tuser
);

    // a stalled result holds
    `MFPS_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // reset empties the result queue
    `MFPS_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // with nothing queued, credit is always available
    `MFPS_ASSERT_NOW(a_credit_free, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty result queue")

    // a fresh result traces back to a final-cell transfer through stages B, C and the queue
    `MFPS_ASSERT_NOW(a_result_origin, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast, 3), "result without a final cell")

endmodule

bind max_falling_path_sum mfps_port_checker u_mfps_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/tb_max_falling_path_sum.sv
// Self-checking testbench of the streaming max falling path sum block.
`timescale 1ns / 1ps

module tb_max_falling_path_sum;
    import mfps_pkg::*;

    localparam int  COLS              = MAX_COLS_DEF;
    localparam time HALF_PERIOD       = 10ns;
    localparam int  DRAIN_CYCLES      = 8;
    localparam int  SETTINGS_PER_MODE = 6;
    localparam int  CELLS_PER_SETTING = 40;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [CELL_W-1:0] value;
        logic              last;
    } cell_t;

    // DUT ports, inputs all known from time zero
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [CELL_W-1:0] s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [SUM_W-1:0]  m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // stimulus bookkeeping
    cell_t      cell_queue[$];
    out_item_t  pending_results[$];
    idle_mode_t idle_mode      = IDLE_NONE;
    int         cells_queued   = 0;
    int         cells_accepted = 0;
    int         cfg_writes     = 0;
    int         fail_count     = 0;
    bit         cell_taken     = 1'b0;

    // path-sum tracker, mirrors the block's state
    logic [CFG_W-1:0]   row_width_reg = ROW_WIDTH_RESET;
    logic signed [31:0] path_sums [COLS];
    logic signed [31:0] prev_left_sum = '0;
    logic signed [31:0] row_best      = SUM_MIN;
    int unsigned        next_col      = 0;
    bit                 in_first_row  = 1'b1;
    bit                 clip_seen     = 1'b0;

    out_item_t want;
    cell_t     nxt;

    max_falling_path_sum uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // register value -> columns actually used (0 acts as 1, clipped to COLS)
    function automatic int unsigned cols_in_use(input int unsigned w);
        if (w < 1) return 1;
        if (w > COLS) return COLS;
        return w;
    endfunction

    // fold one accepted cell into the tracked state; a final cell yields a result
    task automatic predict_cell(input logic [CELL_W-1:0] raw, input logic last);
        int unsigned        w;
        int unsigned        c;
        longint             best;
        longint             total;
        logic signed [31:0] above;
        w = cols_in_use(row_width_reg);
        c = (next_col >= w) ? w - 1 : next_col;   // width shrunk under an open row
        above = path_sums[c];
        if (in_first_row) begin
            total = longint'($signed(raw));
        end else begin
            best = longint'(above);
            if (c > 0 && longint'(prev_left_sum) > best) best = longint'(prev_left_sum);
            if (c + 1 < w && longint'(path_sums[c + 1]) > best) best = longint'(path_sums[c + 1]);
            total = longint'($signed(raw)) + best;
            if (total > longint'(SUM_MAX)) begin
                total = longint'(SUM_MAX);
                clip_seen = 1'b1;
            end else if (total < longint'(SUM_MIN)) begin
                total = longint'(SUM_MIN);
                clip_seen = 1'b1;
            end
        end
        prev_left_sum = above;
        path_sums[c] = total[31:0];
        if (total > longint'(row_best)) row_best = total[31:0];
        if (last) begin
            pending_results.push_back('{saturated: clip_seen, best_sum: row_best});
            next_col     = 0;
            in_first_row = 1'b1;
            row_best     = SUM_MIN;
            clip_seen    = 1'b0;
        end else if (c + 1 >= w) begin
            next_col     = 0;
            in_first_row = 1'b0;
            row_best     = SUM_MIN;
        end else begin
            next_col = c + 1;
        end
    endtask

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 55;
            IDLE_BOTH: return $urandom_range(99) < 19;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 55;
            IDLE_BOTH: return $urandom_range(99) < 19;
            default:   return 1'b0;
        endcase
    endfunction

    // observe input and register transfers at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                row_width_reg = cfg_data;
                cfg_writes++;
            end
            if (s_tvalid && s_tready) begin
                predict_cell(s_tdata, s_tlast);
                cells_accepted++;
                cell_taken = 1'b1;
            end
        end
    end

    // cell driver: next item goes out at the falling edge once the current one is taken
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || cell_taken)) begin
            cell_taken = 1'b0;
            if (cell_queue.size() != 0 && !sender_pauses()) begin
                nxt = cell_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.value;
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (aresetn) m_tready <= !receiver_stalls();
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: best_sum %0d saturated %0d",
                       $signed(m_tdata), m_tuser[0]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.best_sum) begin
                    $error("best_sum mismatch: expected %0d, got %0d",
                           $signed(want.best_sum), $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $error("saturated mismatch: expected %0d, got %0d",
                           want.saturated, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_cell(input int value, input bit last);
        cell_queue.push_back('{value: value[CELL_W-1:0], last: last});
        cells_queued++;
    endtask

    // wait until every cell is taken and every result is out, then let the pipe drain
    task automatic settle();
        do @(negedge aclk);
        while (cells_accepted != cells_queued || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // call from a falling edge with the block idle
    task automatic write_row_width(input int value);
        int seen;
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_data  <= value[CFG_W-1:0];
        do @(negedge aclk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CELL_W-1:0] random_cell();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return CELL_W'($urandom_range(16)) - 16'd8;
            default: return CELL_W'($urandom);
        endcase
    endfunction

    // one matrix of whole rows, or cut short mid-row; leave_open drops the final flag
    task automatic queue_matrix(input int unsigned eff, input bit leave_open, output int cells);
        int rows;
        rows  = (eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
        cells = rows * eff;
        if ($urandom_range(99) < 30) cells = $urandom_range(1, cells);
        for (int k = 0; k < cells; k++) push_cell(random_cell(), !leave_open && k == cells - 1);
    endtask

    // register values that each idle mode starts with: extremes first
    function automatic int edge_width(input int mode, input int step);
        case (mode * 2 + step)
            0:       return 127;
            1:       return 65;
            2:       return 64;
            3:       return 2;
            4:       return 1;
            5:       return 100;
            6:       return 0;
            default: return 3;
        endcase
    endfunction

    initial begin
        int          v;
        int          n;
        int          budget;
        int unsigned cur_eff;
        bit          open_matrix;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset width of 4, cell extremes, final cell mid-row
        push_cell(32767, 0);  push_cell(-32768, 0); push_cell(0, 0);  push_cell(1, 0);
        push_cell(-32768, 0); push_cell(32767, 0);  push_cell(-1, 0); push_cell(0, 0);
        push_cell(5, 0);      push_cell(-9, 1);
        push_cell(-32768, 1);                      // single-cell matrix
        settle();
        write_row_width(1);                        // single column
        push_cell(5, 0); push_cell(-7, 0); push_cell(32767, 1);
        settle();
        write_row_width(0);                        // zero width acts as one
        push_cell(-1, 0); push_cell(-32768, 1);
        settle();
        write_row_width(3);                        // leave a row open at column 2
        push_cell(7, 0); push_cell(8, 0); push_cell(9, 0); push_cell(-1, 0); push_cell(-2, 0);
        settle();
        write_row_width(2);                        // open column now beyond the width
        push_cell(100, 0); push_cell(3, 0); push_cell(4, 1);
        cur_eff     = 2;
        open_matrix = 1'b0;

        // random: four idle modes, several register settings each
        for (int m = 0; m < 4; m++) begin
            idle_mode = idle_mode_t'(m);
            for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
                // with a matrix still open only shrink, so no unwritten column is read
                if (open_matrix)         v = $urandom_range(cur_eff);
                else if (s < 2)          v = edge_width(m, s);
                else if ($urandom_range(99) < 70) v = $urandom_range(1, 8);
                else                     v = $urandom_range(0, 127);
                settle();
                write_row_width(v);
                cur_eff     = cols_in_use(v);
                open_matrix = 1'b0;
                budget      = CELLS_PER_SETTING;
                while (budget > 0) begin
                    queue_matrix(cur_eff, 1'b0, n);
                    budget -= n;
                end
                if (!(m == 3 && s == SETTINGS_PER_MODE - 1) && $urandom_range(3) == 0) begin
                    queue_matrix(cur_eff, 1'b1, n);
                    open_matrix = 1'b1;
                end
            end
        end

        settle();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mfps_pkg.sv
rtl/mfps_row_mem.sv
rtl/mfps_out_fifo.sv
rtl/max_falling_path_sum.sv
rtl/mfps_port_checker.sv
tb/tb_max_falling_path_sum.sv
